// ===== sv/gasa_pkg.sv =====
// Package for the glyph atlas shelf allocator.
// Holds field widths, register indexes and the structs shared by the shelf cells
// and the top level. It has no dependencies.
`timescale 1ns / 1ps

package gasa_pkg;

  localparam int unsigned GLYPH_W   = 10;  // glyph width and height
  localparam int unsigned PITCH_W   = 11;  // signed source pitch
  localparam int unsigned PAD_W     = 14;  // padded width, up to 1024 * 8
  localparam int unsigned ROW_END_W = 11;  // recorded row end
  localparam int unsigned X_W       = 12;  // row end rounded up to eight
  localparam int unsigned FIT_W     = 15;  // x plus padded width
  localparam int unsigned XPOS_W    = 9;
  localparam int unsigned XEND_W    = 10;
  localparam int unsigned RH_W      = 10;  // row_height register
  localparam int unsigned RC_W      = 7;   // row_count register
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [RH_W-1:0]      ROW_HEIGHT_RST = RH_W'(16);
  localparam logic [RC_W-1:0]      ROW_COUNT_RST  = RC_W'(32);
  localparam logic [ROW_END_W-1:0] ROW_END_MAX    = {ROW_END_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_HEIGHT = 8'd0,
    CFG_ROW_COUNT  = 8'd1
  } gasa_cfg_idx_e;

  // Broadcast from the top level to every shelf cell.
  typedef struct packed {
    logic             shift;   // tokens advance one cell
    logic             flush;   // drop any token left in the chain
    logic [PAD_W-1:0] padded;
    logic [GLYPH_W-1:0] width;
  } gasa_ctl_t;

  // What one shelf cell reports back.
  typedef struct packed {
    logic           hit;
    logic [X_W-1:0] x;
  } gasa_res_t;

  function automatic logic [X_W-1:0] round_up8(input logic [X_W-1:0] v);
    logic [X_W-1:0] s;
    s = v + X_W'(7);
    return {s[X_W-1:3], 3'b000};
  endfunction

endpackage

// ===== sv/gasa_if.sv =====
// Channel interfaces for the glyph atlas shelf allocator: request, result and
// configuration write. Depends on gasa_pkg for the field widths.
`timescale 1ns / 1ps

interface gasa_in_if;
  import gasa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [GLYPH_W-1:0]         glyph_width;
  logic [GLYPH_W-1:0]         glyph_height;
  logic signed [PITCH_W-1:0]  row_pitch;
  logic                       mono;
  logic                       has_pixels;

  modport source (output valid, glyph_width, glyph_height, row_pitch, mono, has_pixels,
                  input ready);
  modport sink   (input valid, glyph_width, glyph_height, row_pitch, mono, has_pixels,
                  output ready);
endinterface

interface gasa_out_if;
  import gasa_pkg::*;
  logic                valid;
  logic                ready;
  logic                status;
  logic [XPOS_W-1:0]   x_pos;
  logic [XPOS_W-1:0]   y_pos;
  logic [XEND_W-1:0]   x_end;
  logic [XEND_W-1:0]   y_end;
  logic                flip_v;

  modport source (output valid, status, x_pos, y_pos, x_end, y_end, flip_v, input ready);
  modport sink   (input valid, status, x_pos, y_pos, x_end, y_end, flip_v, output ready);
endinterface

interface gasa_cfg_if;
  import gasa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/gasa_cell.sv =====
// One shelf row of the allocator: holds the row's used flag and end column,
// tests a glyph when the search token sits here and passes the token on.
// Depends on gasa_pkg.
`timescale 1ns / 1ps

module gasa_cell #(
  parameter int unsigned ATLAS_SIZE = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gasa_pkg::gasa_ctl_t ctl_i,
  input  logic                tok_i,
  output logic                tok_o,
  output gasa_pkg::gasa_res_t res_o
);
  import gasa_pkg::*;

  localparam logic [FIT_W-1:0] ATLAS_LIM = FIT_W'(ATLAS_SIZE);

  logic                 tok_q, tok_d;
  logic                 used_q, used_d;
  logic [ROW_END_W-1:0] end_q, end_d;
  logic [X_W-1:0]       x_c;
  logic [FIT_W-1:0]     reach;
  logic [X_W:0]         end_new;
  logic                 fit;
  logic                 hit;

  always_comb begin
    x_c     = used_q ? round_up8(X_W'(end_q)) : '0;
    reach   = FIT_W'(x_c) + FIT_W'(ctl_i.padded);
    // An empty row takes the glyph with no fit check.
    fit     = !used_q || (reach <= ATLAS_LIM);
    hit     = tok_q && ctl_i.shift && fit;
    end_new = (X_W + 1)'(x_c) + (X_W + 1)'(ctl_i.width);
  end

  always_comb begin
    tok_d  = tok_q;
    used_d = used_q;
    end_d  = end_q;
    if (ctl_i.flush) begin
      tok_d = 1'b0;
    end else if (ctl_i.shift) begin
      tok_d = tok_i;
    end
    if (hit) begin
      used_d = 1'b1;
      end_d  = (end_new > (X_W + 1)'(ROW_END_MAX)) ? ROW_END_MAX : end_new[ROW_END_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      used_q <= 1'b0;
      end_q  <= '0;
    end else begin
      tok_q  <= tok_d;
      used_q <= used_d;
      end_q  <= end_d;
    end
  end

  assign tok_o     = tok_q && ctl_i.shift && !fit;
  assign res_o.hit = hit;
  assign res_o.x   = x_c;

endmodule

// ===== sv/glyph_atlas_shelf_allocator_top.sv =====
// Glyph atlas shelf allocator, top level. A search token walks a chain of shelf cells,
// one row per cycle, until a row takes the glyph or min(row_count, MAX_ROWS) rows are
// passed and the glyph is refused. One request is in flight at a time and a new one is
// taken the cycle after the result is registered; a waiting result holds the scan. Reset
// is asynchronous, active low: all rows become empty and row_height 16, row_count 32 return.
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_top #(
  parameter int unsigned ATLAS_SIZE = 512,
  parameter int unsigned MAX_ROWS   = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gasa_in_if.sink    in_i,
  gasa_out_if.source out_o,
  gasa_cfg_if.sink   cfg_i
);
  import gasa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W = (CNT_W > RC_W) ? CNT_W : RC_W;
  localparam logic [CMP_W-1:0] MAX_ROWS_C = CMP_W'(MAX_ROWS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [XEND_W-1:0]   y_q, y_d;
  logic [RH_W-1:0]     row_height_q;
  logic [RC_W-1:0]     row_count_q;

  logic [GLYPH_W-1:0]  width_q;
  logic [GLYPH_W-1:0]  height_q;
  logic [PAD_W-1:0]    padded_q;
  logic                flip_q;

  logic                out_valid_q;
  logic                status_q;
  logic [XPOS_W-1:0]   x_pos_q, y_pos_q;
  logic [XEND_W-1:0]   x_end_q, y_end_q;
  logic                flip_out_q;

  logic                in_acc;
  logic                out_free;
  logic                last_row;
  logic                step;
  logic                any_hit;
  logic [X_W-1:0]      hit_x;
  logic [CMP_W-1:0]    rows_lim;
  logic [PITCH_W-1:0]  praw;
  logic [PITCH_W-1:0]  upitch;
  logic [PAD_W-1:0]    padded_c;
  logic [PAD_W-1:0]    pad_sum;
  logic [X_W-1:0]      x_end_full;

  gasa_ctl_t           ctl;
  gasa_res_t           res   [MAX_ROWS];
  logic                tok_in [MAX_ROWS];
  logic                tok_out[MAX_ROWS];

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_height_q <= ROW_HEIGHT_RST;
      row_count_q  <= ROW_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ROW_HEIGHT: row_height_q <= cfg_i.data[RH_W-1:0];
        CFG_ROW_COUNT:  row_count_q  <= cfg_i.data[RC_W-1:0];
        default: ;
      endcase
    end
  end

  // Padded width of the request.
  always_comb begin
    praw     = $unsigned(in_i.row_pitch);
    upitch   = praw[PITCH_W-1] ? (PITCH_W'(0) - praw) : praw;
    pad_sum  = PAD_W'(upitch) + PAD_W'(7);
    padded_c = in_i.mono ? {upitch, 3'b000} : {pad_sum[PAD_W-1:3], 3'b000};
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    rows_lim = (CMP_W'(row_count_q) > MAX_ROWS_C) ? MAX_ROWS_C : CMP_W'(row_count_q);
    last_row = (CMP_W'(cnt_q) == rows_lim);
    step     = (state_q == ST_SCAN) && out_free && !last_row;
  end

  always_comb begin
    ctl.shift  = step || in_acc;
    ctl.flush  = (state_q == ST_SCAN) && out_free && last_row;
    ctl.padded = padded_q;
    ctl.width  = width_q;
  end

  generate
    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign tok_in[i] = in_acc;
      end else begin : g_link
        assign tok_in[i] = tok_out[i-1];
      end
      gasa_cell #(
        .ATLAS_SIZE(ATLAS_SIZE)
      ) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (ctl),
        .tok_i (tok_in[i]),
        .tok_o (tok_out[i]),
        .res_o (res[i])
      );
    end
  endgenerate

  // At most one cell hits, so the results merge by OR.
  always_comb begin
    any_hit = 1'b0;
    hit_x   = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      any_hit = any_hit | res[i].hit;
      hit_x   = hit_x | (res[i].hit ? res[i].x : '0);
    end
    x_end_full = hit_x + X_W'(width_q);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    y_d     = y_q;
    if (in_acc) begin
      state_d = ST_SCAN;
      cnt_d   = '0;
      y_d     = '0;
    end else if (ctl.flush || (step && any_hit)) begin
      state_d = ST_IDLE;
    end else if (step) begin
      cnt_d = cnt_q + CNT_W'(1);
      y_d   = y_q + row_height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      y_q     <= y_d;
      if (ctl.flush || (step && any_hit)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      width_q  <= in_i.glyph_width;
      height_q <= in_i.glyph_height;
      padded_q <= padded_c;
      flip_q   <= in_i.row_pitch[PITCH_W-1] && !in_i.has_pixels;
    end
    if (ctl.flush) begin
      status_q   <= 1'b1;
      x_pos_q    <= '0;
      y_pos_q    <= '0;
      x_end_q    <= '0;
      y_end_q    <= '0;
      flip_out_q <= 1'b0;
    end else if (step && any_hit) begin
      status_q   <= 1'b0;
      x_pos_q    <= hit_x[XPOS_W-1:0];
      y_pos_q    <= y_q[XPOS_W-1:0];
      x_end_q    <= x_end_full[XEND_W-1:0];
      y_end_q    <= y_q + XEND_W'(height_q);
      flip_out_q <= flip_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = status_q;
  assign out_o.x_pos  = x_pos_q;
  assign out_o.y_pos  = y_pos_q;
  assign out_o.x_end  = x_end_q;
  assign out_o.y_end  = y_end_q;
  assign out_o.flip_v = flip_out_q;

endmodule

// ===== sv/gasa_checker.sv =====
// Port-level checks for the glyph atlas shelf allocator, attached to the top level
// by the bind statement at the end. Depends on gasa_pkg for the field widths.
`timescale 1ns / 1ps

module gasa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         status,
  input logic [gasa_pkg::XPOS_W-1:0]  x_pos,
  input logic [gasa_pkg::XPOS_W-1:0]  y_pos,
  input logic [gasa_pkg::XEND_W-1:0]  x_end,
  input logic [gasa_pkg::XEND_W-1:0]  y_end,
  input logic                         flip_v
);
  import gasa_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // A refused glyph reports all coordinates as zero.
  a_no_space_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status |-> (x_pos == '0) && (y_pos == '0) && (x_end == '0)
                            && (y_end == '0) && !flip_v)
    else $error("no-space result carries nonzero coordinates");

  // Placement columns always sit on an eight-pixel boundary.
  a_x_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (x_pos[2:0] == 3'b000))
    else $error("placed column is not a multiple of eight");

  // A scan is under way after acceptance, so a request is never followed at once by another.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request transaction accepted while a scan is running");

endmodule

bind glyph_atlas_shelf_allocator_top gasa_checker u_gasa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_i.valid),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .status   (out_o.status),
  .x_pos    (out_o.x_pos),
  .y_pos    (out_o.y_pos),
  .x_end    (out_o.x_end),
  .y_end    (out_o.y_end),
  .flip_v   (out_o.flip_v)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the glyph atlas shelf allocator: it drives requests
// and register writes, predicts every placement and compares each result field.
// Depends on gasa_pkg, the channel interfaces and glyph_atlas_shelf_allocator_top.
`timescale 1ns / 1ps

module testbench;
  import gasa_pkg::*;

  localparam int unsigned ATLAS_PX   = 512;
  localparam int unsigned SHELF_ROWS = 64;
  localparam logic        STATUS_PLACED   = 1'b0;
  localparam logic        STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic [GLYPH_W-1:0]        width;
    logic [GLYPH_W-1:0]        height;
    logic signed [PITCH_W-1:0] pitch;
    logic                      mono;
    logic                      has_pixels;
  } glyph_req_t;

  typedef struct packed {
    logic              status;
    logic [XPOS_W-1:0] x_pos;
    logic [XPOS_W-1:0] y_pos;
    logic [XEND_W-1:0] x_end;
    logic [XEND_W-1:0] y_end;
    logic              flip_v;
  } placement_t;

  class shelf_scoreboard;
    bit          row_used [SHELF_ROWS];
    int unsigned row_end  [SHELF_ROWS];
    int unsigned row_height;
    int unsigned row_count;
    placement_t  expected_places [$];
    int unsigned mismatch_count;

    function new();
      row_height     = 32'(ROW_HEIGHT_RST);
      row_count      = 32'(ROW_COUNT_RST);
      mismatch_count = 0;
      foreach (row_used[i]) begin
        row_used[i] = 1'b0;
        row_end[i]  = 0;
      end
    endfunction

    function void write_register(gasa_cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_ROW_HEIGHT: row_height = 32'(data[RH_W-1:0]);
        CFG_ROW_COUNT:  row_count  = 32'(data[RC_W-1:0]);
        default: ;
      endcase
    endfunction

    // Scans the shelves from the top and books the glyph into the first row that
    // takes it. An empty row takes any glyph; a used row needs room for the padding.
    function placement_t place_glyph(glyph_req_t req);
      logic [PITCH_W-1:0] praw;
      int unsigned        magnitude, padded, rows, row, xv, endv, yv;
      bit                 found;
      placement_t         p;
      praw      = req.pitch;
      magnitude = praw[PITCH_W-1] ? 2048 - int'(praw) : int'(praw);
      padded    = req.mono ? magnitude * 8 : (magnitude + 7) & ~32'd7;
      rows      = (row_count < SHELF_ROWS) ? row_count : SHELF_ROWS;
      found     = 1'b0;
      xv        = 0;
      for (row = 0; row < rows; row++) begin
        if (!row_used[row]) begin
          xv    = 0;
          found = 1'b1;
          break;
        end
        xv = (row_end[row] + 7) & ~32'd7;
        if (xv + padded <= ATLAS_PX) begin
          found = 1'b1;
          break;
        end
      end
      p = '0;
      if (!found) begin
        p.status = STATUS_NO_SPACE;
        return p;
      end
      yv            = row * row_height;
      endv          = xv + 32'(req.width);
      row_used[row] = 1'b1;
      row_end[row]  = (endv > 32'(ROW_END_MAX)) ? 32'(ROW_END_MAX) : endv;
      p.status      = STATUS_PLACED;
      p.x_pos       = xv[XPOS_W-1:0];
      p.y_pos       = yv[XPOS_W-1:0];
      p.x_end       = endv[XEND_W-1:0];
      yv            = yv + 32'(req.height);
      p.y_end       = yv[XEND_W-1:0];
      p.flip_v      = praw[PITCH_W-1] && !req.has_pixels;
      return p;
    endfunction

    function void note_request(glyph_req_t req);
      expected_places = {expected_places, place_glyph(req)};
    endfunction

    function int unsigned pending();
      return expected_places.size();
    endfunction

    task report(string what, int unsigned want, int unsigned got);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
    endtask

    task check_result(placement_t got);
      placement_t want;
      if (expected_places.size() == 0) begin
        report("result with no request pending", 0, 1);
        return;
      end
      want = expected_places.pop_front();
      if (got.status != want.status)
        report("status", 32'(want.status), 32'(got.status));
      if (got.x_pos != want.x_pos)
        report("x_pos", 32'(want.x_pos), 32'(got.x_pos));
      if (got.y_pos != want.y_pos)
        report("y_pos", 32'(want.y_pos), 32'(got.y_pos));
      if (got.x_end != want.x_end)
        report("x_end", 32'(want.x_end), 32'(got.x_end));
      if (got.y_end != want.y_end)
        report("y_end", 32'(want.y_end), 32'(got.y_end));
      if (got.flip_v != want.flip_v)
        report("flip_v", 32'(want.flip_v), 32'(got.flip_v));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  gasa_in_if  glyph_if ();
  gasa_out_if place_if ();
  gasa_cfg_if cfg_if ();

  shelf_scoreboard atlas_sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  logic            results_held;

  glyph_atlas_shelf_allocator_top #(
    .ATLAS_SIZE(ATLAS_PX),
    .MAX_ROWS  (SHELF_ROWS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_i (glyph_if),
    .out_o(place_if),
    .cfg_i(cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: checks every transaction and stalls at random or on hold-off.
  initial begin
    placement_t got;
    place_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && place_if.valid && place_if.ready) begin
        got.status = place_if.status;
        got.x_pos  = place_if.x_pos;
        got.y_pos  = place_if.y_pos;
        got.x_end  = place_if.x_end;
        got.y_end  = place_if.y_end;
        got.flip_v = place_if.flip_v;
        atlas_sb.check_result(got);
      end
      place_if.ready <= !results_held && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic glyph_req_t make_glyph(int unsigned w, int unsigned h, int p, bit m,
                                            bit hp);
    glyph_req_t req;
    req.width      = GLYPH_W'(w);
    req.height     = GLYPH_W'(h);
    req.pitch      = PITCH_W'(p);
    req.mono       = m;
    req.has_pixels = hp;
    return req;
  endfunction

  // Mostly glyphs whose width stays inside the padding, so shelves fill slowly;
  // a few requests take any value the fields allow.
  function automatic glyph_req_t random_glyph();
    glyph_req_t  req;
    int unsigned mag;
    if ($urandom_range(99) < 3) begin
      req.width      = GLYPH_W'($urandom);
      req.height     = GLYPH_W'($urandom);
      req.pitch      = PITCH_W'($urandom);
      req.mono       = 1'($urandom_range(1));
      req.has_pixels = 1'($urandom_range(1));
    end else begin
      req.mono       = ($urandom_range(4) == 0);
      mag            = req.mono ? $urandom_range(3) : $urandom_range(24);
      req.width      = GLYPH_W'($urandom_range(0, req.mono ? mag * 8 : mag));
      req.height     = GLYPH_W'($urandom_range(64));
      req.pitch      = PITCH_W'($urandom_range(1) ? -int'(mag) : int'(mag));
      req.has_pixels = 1'($urandom_range(1));
    end
    return req;
  endfunction

  task automatic offer_glyph(glyph_req_t req);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      glyph_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    glyph_if.valid        <= 1'b1;
    glyph_if.glyph_width  <= req.width;
    glyph_if.glyph_height <= req.height;
    glyph_if.row_pitch    <= req.pitch;
    glyph_if.mono         <= req.mono;
    glyph_if.has_pixels   <= req.has_pixels;
    do @(posedge clk_i); while (!glyph_if.ready);
    atlas_sb.note_request(req);
  endtask

  // Registers change only once every placement in flight has come back.
  task automatic write_register(gasa_cfg_idx_e idx, int unsigned value);
    logic [CFG_DAT_W-1:0] word;
    word = CFG_DAT_W'($urandom);
    if (idx == CFG_ROW_HEIGHT) word[RH_W-1:0] = value[RH_W-1:0];
    else word[RC_W-1:0] = value[RC_W-1:0];
    glyph_if.valid <= 1'b0;
    while (atlas_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    atlas_sb.write_register(idx, word);
  endtask

  initial begin
    int unsigned phase_heights [5] = '{8, 512, 24, 16, 40};
    int unsigned phase_counts  [5] = '{16, 32, 48, 64, 127};
    int unsigned phase_idle    [5] = '{0, 77, 0, 27, 0};
    int unsigned phase_stall   [5] = '{0, 0, 77, 27, 0};
    atlas_sb               = new();
    rst_ni                 = 1'b0;
    glyph_if.valid         = 1'b0;
    glyph_if.glyph_width   = '0;
    glyph_if.glyph_height  = '0;
    glyph_if.row_pitch     = '0;
    glyph_if.mono          = 1'b0;
    glyph_if.has_pixels    = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = CFG_ROW_HEIGHT;
    cfg_if.data            = '0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    results_held           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty rows, exact fit at the atlas edge, flips, pitch extremes.
    offer_glyph(make_glyph(0, 0, 0, 0, 0));
    offer_glyph(make_glyph(8, 1023, 8, 0, 0));
    offer_glyph(make_glyph(5, 0, -3, 0, 0));
    offer_glyph(make_glyph(100, 7, -3, 0, 1));
    offer_glyph(make_glyph(392, 0, 392, 0, 1));
    offer_glyph(make_glyph(1023, 1023, 1, 0, 0));
    offer_glyph(make_glyph(7, 3, -1024, 1, 0));
    offer_glyph(make_glyph(8, 0, 1, 1, 1));
    offer_glyph(make_glyph(512, 512, 1023, 0, 0));
    offer_glyph(make_glyph(3, 0, -1, 1, 1));
    offer_glyph(make_glyph(600, 0, -512, 0, 0));

    // No rows at all: every request finds no space.
    write_register(CFG_ROW_COUNT, 0);
    write_register(CFG_ROW_HEIGHT, 0);
    offer_glyph(make_glyph(1, 1, 1, 0, 0));
    offer_glyph(make_glyph(0, 0, 0, 1, 1));

    // One row, already filled to the edge; coordinates wrap.
    write_register(CFG_ROW_COUNT, 1);
    write_register(CFG_ROW_HEIGHT, 1023);
    offer_glyph(make_glyph(0, 0, 0, 0, 0));
    offer_glyph(make_glyph(0, 1023, 0, 0, 1));
    offer_glyph(make_glyph(4, 0, 8, 0, 0));

    // Row count beyond the row table, tall rows so y wraps.
    write_register(CFG_ROW_COUNT, 127);
    write_register(CFG_ROW_HEIGHT, 512);
    offer_glyph(make_glyph(20, 100, 600, 0, 0));
    offer_glyph(make_glyph(2, 5, 2, 0, 0));
    offer_glyph(make_glyph(9, 1023, 1023, 1, 1));

    for (int ph = 0; ph < 5; ph++) begin
      write_register(CFG_ROW_HEIGHT, phase_heights[ph]);
      write_register(CFG_ROW_COUNT, phase_counts[ph]);
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      if (ph == 4) begin
        // Hold results back long enough that the block stalls its request side.
        fork
          begin
            repeat (20) @(posedge clk_i);
            results_held <= 1'b1;
            repeat (400) @(posedge clk_i);
            results_held <= 1'b0;
          end
          begin
            for (int n = 0; n < 320; n++) offer_glyph(random_glyph());
          end
        join
      end else begin
        for (int n = 0; n < 320; n++) offer_glyph(random_glyph());
      end
    end

    glyph_if.valid <= 1'b0;
    while (atlas_sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (atlas_sb.pending() != 0)
      atlas_sb.report("requests left without a result", 0, atlas_sb.pending());
    if (atlas_sb.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
